[sv/utf8_cesu8_codepoint_encoder_assert.svh]
// assertion macros for the code point encoder modules, used by the serializer
`ifndef UTF8_CESU8_CODEPOINT_ENCODER_ASSERT_SVH
`define UTF8_CESU8_CODEPOINT_ENCODER_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define UCC_ASSERT_SAME(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define UCC_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/ucc_pkg.sv]
// shared types and constants for the code point encoder
`default_nettype none

package ucc_pkg;

    localparam int MAX_BYTES = 7;
    localparam int LEN_W     = 3;

    typedef logic [7:0]       byte_t;
    typedef logic [LEN_W-1:0] len_t;

    // encoding scheme selected by the mode register
    typedef enum logic {
        MODE_XUTF8 = 1'b0,
        MODE_CESU8 = 1'b1
    } enc_mode_t;

    // one encoded sequence, lead byte in entry 0
    typedef struct packed {
        byte_t [MAX_BYTES-1:0] bytes;
        len_t                  len;
    } seq_t;

    // lead byte markers, indexed by sequence length minus one
    localparam byte_t LEAD_MARKER [MAX_BYTES] = '{
        8'h00, 8'hc0, 8'he0, 8'hf0, 8'hf8, 8'hfc, 8'hfe
    };

    localparam byte_t CONT_MARKER   = 8'h80;
    localparam byte_t SURR_LEAD     = 8'hed;
    localparam byte_t SURR_HI_MARK  = 8'ha0;
    localparam byte_t SURR_LO_MARK  = 8'hb0;
    localparam logic [19:0] SUPP_BASE = 20'h10000;

endpackage

`default_nettype wire

[sv/ucc_encode.sv]
// combinational encoder: code point and mode to a byte sequence
`default_nettype none

module ucc_encode
    import ucc_pkg::*;
(
    input  logic [31:0] code_point,
    input  enc_mode_t   mode,
    output seq_t        seq
);

    logic [35:0]       cp_wide;
    byte_t [5:0]       cont;
    len_t              xlen;
    byte_t             lead;
    logic [19:0]       surr;
    logic              supp;

    // extended length by value threshold
    always_comb begin
        priority if (code_point < 32'h80)       xlen = 3'd1;
        else if (code_point < 32'h800)          xlen = 3'd2;
        else if (code_point < 32'h10000)        xlen = 3'd3;
        else if (code_point < 32'h200000)       xlen = 3'd4;
        else if (code_point < 32'h4000000)      xlen = 3'd5;
        else if (code_point < 32'h80000000)     xlen = 3'd6;
        else                                    xlen = 3'd7;
    end

    // continuation bytes, six value bits each, lowest group first
    assign cp_wide = {4'b0000, code_point};
    always_comb begin
        for (int j = 0; j < 6; j++) begin
            cont[j] = CONT_MARKER | {2'b00, cp_wide[6*j +: 6]};
        end
    end

    // lead byte: marker plus the bits left above the continuation bytes
    always_comb begin
        unique case (xlen)
            3'd1:    lead = code_point[7:0];
            3'd2:    lead = LEAD_MARKER[1] | {3'b000, code_point[10:6]};
            3'd3:    lead = LEAD_MARKER[2] | {4'b0000, code_point[15:12]};
            3'd4:    lead = LEAD_MARKER[3] | {5'b00000, code_point[20:18]};
            3'd5:    lead = LEAD_MARKER[4] | {6'b000000, code_point[25:24]};
            3'd6:    lead = LEAD_MARKER[5] | {7'b0000000, code_point[30]};
            3'd7:    lead = LEAD_MARKER[6];
            default: lead = 8'h00;
        endcase
    end

    // surrogate pair source value, only the low 20 bits survive the masks
    assign surr = code_point[19:0] - SUPP_BASE;
    assign supp = (mode == MODE_CESU8) && (code_point >= 32'h10000);

    // assemble the sequence
    always_comb begin
        logic [2:0] idx;
        seq = '0;
        idx = '0;
        if (supp) begin
            seq.len      = 3'd6;
            seq.bytes[0] = SURR_LEAD;
            seq.bytes[1] = SURR_HI_MARK | {4'b0000, surr[19:16]};
            seq.bytes[2] = CONT_MARKER | {2'b00, surr[15:10]};
            seq.bytes[3] = SURR_LEAD;
            seq.bytes[4] = SURR_LO_MARK | {4'b0000, surr[9:6]};
            seq.bytes[5] = CONT_MARKER | {2'b00, surr[5:0]};
        end else begin
            seq.len      = xlen;
            seq.bytes[0] = lead;
            for (int i = 1; i < MAX_BYTES; i++) begin
                idx = xlen - 3'd1 - 3'(i);
                if (3'(i) < xlen) begin
                    seq.bytes[i] = cont[idx];
                end
            end
        end
    end

endmodule

`default_nettype wire

[sv/ucc_serializer.sv]
// holds one encoded sequence and shifts it out a byte per item
`default_nettype none

module ucc_serializer
    import ucc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        load_valid,
    input  seq_t        load_seq,
    output logic        load_ready,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,
    output logic        m_tlast
);

    logic                  seq_valid_reg, seq_valid_next;
    byte_t [MAX_BYTES-1:0] bytes_reg, bytes_next;
    len_t                  remain_reg, remain_next;
    logic                  fire;
    logic                  on_last;

    assign on_last    = (remain_reg == 3'd1);
    assign fire       = seq_valid_reg && m_tready;
    assign load_ready = !seq_valid_reg || (m_tready && on_last);

    // output side straight from the sequence register
    assign m_tvalid = seq_valid_reg;
    assign m_tdata  = bytes_reg[0];
    assign m_tlast  = on_last;

    // load a new sequence, or shift after each byte taken
    always_comb begin
        seq_valid_next = seq_valid_reg;
        bytes_next     = bytes_reg;
        remain_next    = remain_reg;
        if (load_valid && load_ready) begin
            seq_valid_next = 1'b1;
            bytes_next     = load_seq.bytes;
            remain_next    = load_seq.len;
        end else if (fire) begin
            if (on_last) begin
                seq_valid_next = 1'b0;
            end else begin
                bytes_next  = {8'h00, bytes_reg[MAX_BYTES-1:1]};
                remain_next = remain_reg - 3'd1;
            end
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_valid_reg <= 1'b0;
            remain_reg    <= '0;
        end else begin
            seq_valid_reg <= seq_valid_next;
            remain_reg    <= remain_next;
        end
    end

    // byte payload
    always_ff @(posedge aclk) begin
        bytes_reg <= bytes_next;
    end

`include "utf8_cesu8_codepoint_encoder_assert.svh"

    `UCC_ASSERT_SAME(a_remain_nonzero, aclk, aresetn, seq_valid_reg, remain_reg != 3'd0, "held sequence has no bytes left")
    `UCC_ASSERT_NEXT(a_count_down, aclk, aresetn, fire && !on_last, seq_valid_reg && (remain_reg == 3'($past(remain_reg) - 3'd1)), "byte count did not step down")
    `UCC_ASSERT_NEXT(a_load_takes, aclk, aresetn, load_valid && load_ready, seq_valid_reg && (remain_reg == $past(load_seq.len)), "loaded sequence not held")

endmodule

`default_nettype wire

[sv/utf8_cesu8_codepoint_encoder.sv]
// Code point encoder, extended UTF-8 or CESU-8, one output byte per item.
//
// s_ channel: one 32-bit code point per item. m_ channel: one encoded byte
// per item, lead byte first, m_tlast high on the final byte of a code point.
// cfg channel: encoding mode, 0 extended UTF-8 (1 to 7 bytes), 1 CESU-8
// (1 to 3 bytes, or a 6-byte surrogate pair at and above 0x10000).
// cfg_ready is always high; write the mode only while the block is empty.
//
// Pipeline: a code point passes the input register, then the sequence
// register with encoding between; its bytes leave from the sequence register.
// Throughput: single-byte code points flow at one per cycle while m_tready
// is high; the sequence register shifts out one byte per cycle while m_tready
// is high and sets the rate for longer sequences.
// When m_tready is low the current byte holds and one further code point
// is buffered in the input register before s_tready drops.
// Reset (aresetn low, synchronous) empties both stages and sets mode 0.
`default_nettype none

module utf8_cesu8_codepoint_encoder
    import ucc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // code_point [31:0]
    input  logic [31:0] s_tdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // out_byte [7:0]
    output logic [7:0]  m_tdata,
    output logic        m_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data
);

    enc_mode_t   mode_reg;
    logic        in_valid_reg, in_valid_next;
    logic [31:0] cp_reg;
    seq_t        enc_seq;
    logic        load_ready;

    // mode register
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_XUTF8;
        end else if (cfg_valid) begin
            mode_reg <= enc_mode_t'(cfg_data);
        end
    end

    // input register, freed when the serializer takes its item
    assign s_tready = !in_valid_reg || load_ready;
    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (load_ready) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            cp_reg <= s_tdata;
        end
    end

    // encoding between the two registers
    ucc_encode u_encode (
        .code_point (cp_reg),
        .mode       (mode_reg),
        .seq        (enc_seq)
    );

    // sequence register and byte output
    ucc_serializer u_serializer (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load_valid (in_valid_reg),
        .load_seq   (enc_seq),
        .load_ready (load_ready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

`default_nettype wire

[bench/tb.sv]
// self-checking testbench for the code point encoder, both encoding modes
`default_nettype none

module tb;
    import ucc_pkg::*;

    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 6;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int MAX_REPORTS  = 10;
    localparam int IDLE_PCT     = 31;

    // lead byte markers by sequence length
    localparam logic [7:0] LEAD_1 = 8'h00;
    localparam logic [7:0] LEAD_2 = 8'hc0;
    localparam logic [7:0] LEAD_3 = 8'he0;
    localparam logic [7:0] LEAD_4 = 8'hf0;
    localparam logic [7:0] LEAD_5 = 8'hf8;
    localparam logic [7:0] LEAD_6 = 8'hfc;
    localparam logic [7:0] LEAD_7 = 8'hfe;
    localparam logic [7:0] CONT   = 8'h80;
    localparam logic [7:0] SURR_E = 8'hed;
    localparam logic [7:0] SURR_H = 8'ha0;
    localparam logic [7:0] SURR_L = 8'hb0;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } enc_byte_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic [31:0] s_tdata   = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_data  = 1'b0;

    enc_byte_t   pending_bytes [$];
    enc_byte_t   want;
    enc_mode_t   cur_mode    = MODE_XUTF8;
    int          fail_count  = 0;
    int          tx_idle_pct = IDLE_PCT;
    int          rx_idle_pct = IDLE_PCT;
    int          hold_asked  = 0;
    int          hold_seen   = 0;
    int          hold_left   = 0;
    int          cycles      = 0;

    utf8_cesu8_codepoint_encoder dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),   // code_point [31:0]
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),   // out_byte [7:0]
        .m_tlast   (m_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // clock, period 2
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // predict the byte sequence of one code point in the current mode
    function automatic void queue_encoding(input logic [31:0] cp);
        logic [7:0]  seq [0:6];
        logic [7:0]  lead;
        logic [31:0] rest;
        logic [31:0] y;
        int          n;
        enc_byte_t   b;
        if (cur_mode == MODE_CESU8 && cp >= 32'h10000) begin
            // surrogate pair, high bits of the offset are masked away
            y = cp - 32'h10000;
            seq[0] = SURR_E;
            seq[1] = SURR_H | {4'h0, y[19:16]};
            seq[2] = CONT | {2'b00, y[15:10]};
            seq[3] = SURR_E;
            seq[4] = SURR_L | {4'h0, y[9:6]};
            seq[5] = CONT | {2'b00, y[5:0]};
            n = 6;
        end else begin
            if (cp < 32'h80) begin
                n = 1; lead = LEAD_1;
            end else if (cp < 32'h800) begin
                n = 2; lead = LEAD_2;
            end else if (cp < 32'h10000) begin
                n = 3; lead = LEAD_3;
            end else if (cp < 32'h200000) begin
                n = 4; lead = LEAD_4;
            end else if (cp < 32'h4000000) begin
                n = 5; lead = LEAD_5;
            end else if (cp < 32'h80000000) begin
                n = 6; lead = LEAD_6;
            end else begin
                n = 7; lead = LEAD_7;
            end
            rest = cp;
            for (int i = n - 1; i > 0; i--) begin
                seq[i] = CONT | {2'b00, rest[5:0]};
                rest = rest >> 6;
            end
            seq[0] = lead + rest[7:0];
        end
        for (int k = 0; k < n; k++) begin
            b.value = seq[k];
            b.last  = (k == n - 1);
            pending_bytes.push_back(b);
        end
    endfunction

    // spread values over every length class plus surrogates and full range
    function automatic logic [31:0] random_code_point();
        logic [31:0] v;
        case ($urandom_range(9))
            0, 9: v = $urandom_range(32'h7f);
            1: v = $urandom_range(32'h7ff, 32'h80);
            2: v = $urandom_range(32'hffff, 32'h800);
            3: v = $urandom_range(32'h10ffff, 32'h10000);
            4: v = $urandom_range(32'h1fffff, 32'h110000);
            5: v = $urandom_range(32'h3ffffff, 32'h200000);
            6: v = $urandom_range(32'h7fffffff, 32'h4000000);
            7: v = $urandom_range(32'hdfff, 32'hd800);
            default: v = $urandom();
        endcase
        return v;
    endfunction

    // offer one code point, with random idle cycles ahead of it
    task automatic send_code_point(input logic [31:0] cp);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= cp;
        do @(posedge aclk); while (!s_tready);
        queue_encoding(cp);
    endtask

    // stop offering and wait for every expected byte
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_bytes.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_mode(input enc_mode_t mode);
        cfg_valid <= 1'b1;
        cfg_data  <= mode;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cur_mode = mode;
    endtask

    // thresholds and extremes in the reset mode
    task automatic test_directed_xutf8();
        logic [31:0] pts [14] = '{
            32'h0, 32'h7f, 32'h80, 32'h7ff, 32'h800, 32'hffff, 32'h10000,
            32'h1fffff, 32'h200000, 32'h3ffffff, 32'h4000000, 32'h7fffffff,
            32'h80000000, 32'hffffffff
        };
        foreach (pts[i]) send_code_point(pts[i]);
        drain();
    endtask

    // thresholds, surrogates and values past the top of unicode
    task automatic test_directed_cesu8();
        logic [31:0] pts [11] = '{
            32'h0, 32'h7f, 32'h80, 32'h7ff, 32'h800, 32'hd800, 32'hdfff,
            32'hffff, 32'h10000, 32'h10ffff, 32'h110000
        };
        write_mode(MODE_CESU8);
        foreach (pts[i]) send_code_point(pts[i]);
        send_code_point(32'hffffffff);
        drain();
    endtask

    task automatic test_random_mode(input enc_mode_t mode, input int count);
        write_mode(mode);
        repeat (count) send_code_point(random_code_point());
        drain();
    endtask

    // both sides running flat out
    task automatic test_no_idle(input enc_mode_t mode, input int count);
        write_mode(mode);
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
        repeat (count) send_code_point(random_code_point());
        drain();
        tx_idle_pct = IDLE_PCT;
        rx_idle_pct <= IDLE_PCT;
    endtask

    // receiver holds off while the sender keeps offering
    task automatic test_backpressure(input enc_mode_t mode, input int count);
        write_mode(mode);
        tx_idle_pct = 0;
        hold_asked <= hold_asked + 1;
        repeat (count) send_code_point(random_code_point());
        drain();
        tx_idle_pct = IDLE_PCT;
    endtask

    // receiver ready and result check
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_bytes.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("unexpected byte %02h last %0b", m_tdata, m_tlast);
            end else begin
                want = pending_bytes.pop_front();
                if (m_tdata !== want.value || m_tlast !== want.last) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("byte mismatch: expected %02h last %0b, got %02h last %0b",
                                 want.value, want.last, m_tdata, m_tlast);
                end
            end
        end
        if (hold_seen != hold_asked) begin
            hold_seen <= hold_asked;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // run limit
    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("utf8_cesu8_codepoint_encoder regression: fail");
        $finish;
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_xutf8();
        test_directed_cesu8();
        test_random_mode(MODE_CESU8, 80);
        test_random_mode(MODE_XUTF8, 80);
        test_random_mode(MODE_CESU8, 80);
        test_random_mode(MODE_XUTF8, 80);
        test_no_idle(MODE_CESU8, 60);
        test_backpressure(MODE_XUTF8, 50);
        fail_count += pending_bytes.size();
        if (fail_count == 0)
            $display("utf8_cesu8_codepoint_encoder regression: pass");
        else
            $display("utf8_cesu8_codepoint_encoder regression: fail");
        $finish;
    end

endmodule

`default_nettype wire
